>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the pixel format converter.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/pfc_pkg.sv
// Package for the pixel format converter: format codes, register indexes,
// luma weights and shared types. No dependencies.
`default_nettype none
package pfc_pkg;

  typedef logic [2:0] fmt_t;

  localparam fmt_t FMT_GRAY = 3'd0;
  localparam fmt_t FMT_RGB  = 3'd1;
  localparam fmt_t FMT_BGR  = 3'd2;
  localparam fmt_t FMT_RGBA = 3'd3;
  localparam fmt_t FMT_BGRA = 3'd4;
  localparam fmt_t FMT_ARGB = 3'd5;
  localparam fmt_t FMT_ABGR = 3'd6;

  localparam logic [1:0] CFG_SRC_FMT = 2'd0;
  localparam logic [1:0] CFG_DST_FMT = 2'd1;

  localparam logic [15:0] LUMA_WR = 16'd19595;
  localparam logic [15:0] LUMA_WG = 16'd38470;
  localparam logic [15:0] LUMA_WB = 16'd7471;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

  localparam logic [2:0] CNT_GRAY = 3'd1;
  localparam logic [2:0] CNT_RGB  = 3'd3;
  localparam logic [2:0] CNT_RGBA = 3'd4;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  // load enables of the luma stages
  typedef struct packed {
    logic s2;
    logic s3;
  } pfc_adv_t;

endpackage
`default_nettype wire

>>> rtl/core/pixel_format_converter_unit.sv
// Pixel format converter top level: decode, luma pipeline, encode.
// Depends on pfc_pkg, pfc_luma and assert_macros.svh.
//
// Converts one pixel per clock between gray, RGB, BGR, RGBA, BGRA, ARGB
// and ABGR, with source and target formats set through the cfg port
// (index 0 source, 1 target; code seven acts as gray). The pipeline has
// four register stages (decode, luma products, luma sum, encode), and
// one pixel per cycle is sustained while the output is not stalled; the
// two-step multiply-and-sum of the luma unit sets the depth. Stalls on
// the output back up stage by stage without loss.
// Formats must only change while the pipeline is empty.
`default_nettype none
module pixel_format_converter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // chan_0, chan_1, chan_2, chan_3
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // out_0, out_1, out_2, out_3, out_count, pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [2:0]  cfg_data
);
  import pfc_pkg::*;

  fmt_t src_fmt_r, dst_fmt_r;
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  rgba_t px1_r, px2_r, px3_r, px_dec;
  logic [7:0] luma;
  logic [7:0] o0_r, o1_r, o2_r, o3_r;
  logic [7:0] o0_nxt, o1_nxt, o2_nxt, o3_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  pfc_adv_t adv;
  logic [7:0] c0, c1, c2, c3;
  logic cnt_legal;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_fmt_r <= FMT_GRAY;
      dst_fmt_r <= FMT_GRAY;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SRC_FMT) src_fmt_r <= cfg_data;
      if (cfg_index == CFG_DST_FMT) dst_fmt_r <= cfg_data;
    end
  end

  assign rdy4 = !v4_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  assign c0 = in_tdata[7:0];
  assign c1 = in_tdata[15:8];
  assign c2 = in_tdata[23:16];
  assign c3 = in_tdata[31:24];

  always_comb begin
    case (src_fmt_r)
      FMT_RGB:  px_dec = '{r: c0, g: c1, b: c2, a: ALPHA_OPAQUE};
      FMT_BGR:  px_dec = '{r: c2, g: c1, b: c0, a: ALPHA_OPAQUE};
      FMT_RGBA: px_dec = '{r: c0, g: c1, b: c2, a: c3};
      FMT_BGRA: px_dec = '{r: c2, g: c1, b: c0, a: c3};
      FMT_ARGB: px_dec = '{r: c1, g: c2, b: c3, a: c0};
      FMT_ABGR: px_dec = '{r: c3, g: c2, b: c1, a: c0};
      default:  px_dec = '{r: c0, g: c0, b: c0, a: ALPHA_OPAQUE};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy1) px1_r <= px_dec;
    if (rdy2) px2_r <= px1_r;
    if (rdy3) px3_r <= px2_r;
  end

  assign adv = '{s2: rdy2, s3: rdy3};

  pfc_luma u_luma (
    .clk  (clk),
    .adv  (adv),
    .r    (px1_r.r),
    .g    (px1_r.g),
    .b    (px1_r.b),
    .luma (luma)
  );

  always_comb begin
    o0_nxt  = '0;
    o1_nxt  = '0;
    o2_nxt  = '0;
    o3_nxt  = '0;
    cnt_nxt = CNT_GRAY;
    case (dst_fmt_r)
      FMT_RGB: begin
        o0_nxt = px3_r.r; o1_nxt = px3_r.g; o2_nxt = px3_r.b; cnt_nxt = CNT_RGB;
      end
      FMT_BGR: begin
        o0_nxt = px3_r.b; o1_nxt = px3_r.g; o2_nxt = px3_r.r; cnt_nxt = CNT_RGB;
      end
      FMT_RGBA: begin
        o0_nxt = px3_r.r; o1_nxt = px3_r.g; o2_nxt = px3_r.b; o3_nxt = px3_r.a;
        cnt_nxt = CNT_RGBA;
      end
      FMT_BGRA: begin
        o0_nxt = px3_r.b; o1_nxt = px3_r.g; o2_nxt = px3_r.r; o3_nxt = px3_r.a;
        cnt_nxt = CNT_RGBA;
      end
      FMT_ARGB: begin
        o0_nxt = px3_r.a; o1_nxt = px3_r.r; o2_nxt = px3_r.g; o3_nxt = px3_r.b;
        cnt_nxt = CNT_RGBA;
      end
      FMT_ABGR: begin
        o0_nxt = px3_r.a; o1_nxt = px3_r.b; o2_nxt = px3_r.g; o3_nxt = px3_r.r;
        cnt_nxt = CNT_RGBA;
      end
      default: begin
        o0_nxt = luma; cnt_nxt = CNT_GRAY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      o0_r  <= o0_nxt;
      o1_r  <= o1_nxt;
      o2_r  <= o2_nxt;
      o3_r  <= o3_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {5'd0, cnt_r, o3_r, o2_r, o1_r, o0_r};

  assign cnt_legal = (cnt_r == CNT_GRAY) || (cnt_r == CNT_RGB) || (cnt_r == CNT_RGBA);

`include "assert_macros.svh"

  `ASSERT_SAME(a_cnt_legal, clk, rst_n, out_tvalid, cnt_legal)
  `ASSERT_SAME(a_gray_zero, clk, rst_n, out_tvalid && (cnt_r == CNT_GRAY), {o3_r, o2_r, o1_r} == 24'd0)
  `ASSERT_SAME(a_rgb_no_a, clk, rst_n, out_tvalid && (cnt_r == CNT_RGB), o3_r == 8'd0)
  `ASSERT_NEXT(a_in_loads, clk, rst_n, in_tvalid && in_tready, v1_r)

endmodule
`default_nettype wire

>>> rtl/core/pfc_luma.sv
// Two-stage luma unit: weighted products, then sum and Q16 truncation.
// Depends on pfc_pkg.
`default_nettype none
module pfc_luma (
  input  wire logic             clk,
  input  wire pfc_pkg::pfc_adv_t adv,
  input  wire logic [7:0]       r,
  input  wire logic [7:0]       g,
  input  wire logic [7:0]       b,
  output logic      [7:0]       luma
);
  import pfc_pkg::*;

  logic [23:0] pr_r, pg_r, pb_r;
  logic [24:0] sum;
  logic [7:0]  luma_r;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      pr_r <= 24'(LUMA_WR) * 24'(r);
      pg_r <= 24'(LUMA_WG) * 24'(g);
      pb_r <= 24'(LUMA_WB) * 24'(b);
    end
  end

  assign sum = 25'(pr_r) + 25'(pg_r) + 25'(pb_r);

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      luma_r <= sum[23:16];
    end
  end

  assign luma = luma_r;

endmodule
`default_nettype wire

>>> sim/pixel_format_converter_unit_tb.sv
// Self-checking testbench for pixel_format_converter_unit: walks every source/target
// format pair, predicts each converted pixel and checks every result in order.
// Depends on pfc_pkg and the pixel_format_converter_unit RTL.
`default_nettype none
module pixel_format_converter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfc_pkg::*;

  localparam int PIPE_DEPTH     = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [2:0] cnt;
    logic [7:0] b3;
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
  } pixel_out_t;

  class pixel_conv_model;
    fmt_t       src_fmt;
    fmt_t       dst_fmt;
    pixel_out_t expected_pixels[$];
    int         err_count;

    function new();
      src_fmt   = FMT_GRAY;
      dst_fmt   = FMT_GRAY;
      err_count = 0;
    endfunction

    function void set_format(logic [1:0] idx, fmt_t val);
      if (idx == CFG_SRC_FMT) src_fmt = val;
      else if (idx == CFG_DST_FMT) dst_fmt = val;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void note_pixel(logic [31:0] data);
      logic [7:0]  c0, c1, c2, c3;
      rgba_t       px;
      pixel_out_t  res;
      logic [31:0] luma;
      c0 = data[7:0];
      c1 = data[15:8];
      c2 = data[23:16];
      c3 = data[31:24];
      case (src_fmt)
        FMT_RGB:  begin px.r = c0; px.g = c1; px.b = c2; px.a = ALPHA_OPAQUE; end
        FMT_BGR:  begin px.b = c0; px.g = c1; px.r = c2; px.a = ALPHA_OPAQUE; end
        FMT_RGBA: begin px.r = c0; px.g = c1; px.b = c2; px.a = c3; end
        FMT_BGRA: begin px.b = c0; px.g = c1; px.r = c2; px.a = c3; end
        FMT_ARGB: begin px.a = c0; px.r = c1; px.g = c2; px.b = c3; end
        FMT_ABGR: begin px.a = c0; px.b = c1; px.g = c2; px.r = c3; end
        default:  begin px.r = c0; px.g = c0; px.b = c0; px.a = ALPHA_OPAQUE; end
      endcase
      res = '0;
      case (dst_fmt)
        FMT_RGB:  begin res.b0 = px.r; res.b1 = px.g; res.b2 = px.b; res.cnt = CNT_RGB; end
        FMT_BGR:  begin res.b0 = px.b; res.b1 = px.g; res.b2 = px.r; res.cnt = CNT_RGB; end
        FMT_RGBA: begin
          res.b0 = px.r; res.b1 = px.g; res.b2 = px.b; res.b3 = px.a; res.cnt = CNT_RGBA;
        end
        FMT_BGRA: begin
          res.b0 = px.b; res.b1 = px.g; res.b2 = px.r; res.b3 = px.a; res.cnt = CNT_RGBA;
        end
        FMT_ARGB: begin
          res.b0 = px.a; res.b1 = px.r; res.b2 = px.g; res.b3 = px.b; res.cnt = CNT_RGBA;
        end
        FMT_ABGR: begin
          res.b0 = px.a; res.b1 = px.b; res.b2 = px.g; res.b3 = px.r; res.cnt = CNT_RGBA;
        end
        default: begin
          luma = (32'(LUMA_WR) * 32'(px.r) + 32'(LUMA_WG) * 32'(px.g)
                  + 32'(LUMA_WB) * 32'(px.b)) >> 16;
          res.b0  = luma[7:0];
          res.cnt = CNT_GRAY;
        end
      endcase
      expected_pixels.push_back(res);
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
        err_count++;
      end
    endfunction

    function void check_pixel(logic [39:0] data);
      pixel_out_t got;
      pixel_out_t exp_px;
      got = data[34:0];
      if (expected_pixels.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual %h", $time, got);
        err_count++;
        return;
      end
      exp_px = expected_pixels.pop_front();
      compare_field("out_0", exp_px.b0, got.b0);
      compare_field("out_1", exp_px.b1, got.b1);
      compare_field("out_2", exp_px.b2, got.b2);
      compare_field("out_3", exp_px.b3, got.b3);
      compare_field("out_count", exp_px.cnt, got.cnt);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;    // chan_0, chan_1, chan_2, chan_3
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // out_0, out_1, out_2, out_3, out_count, pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [2:0]  cfg_data = '0;

  pixel_conv_model conv_model = new();
  int ready_pct = 100;
  int ready_left = 0;
  int idle_cycles = 0;

  pixel_format_converter_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: the ready rate is redrawn each time a random-length period runs out
  always @(posedge clk) begin
    if (ready_left == 0) begin
      case ($urandom_range(0, 4))
        0, 1:    ready_pct <= 100;
        2:       ready_pct <= 75;
        3:       ready_pct <= 40;
        default: ready_pct <= 10;
      endcase
      ready_left <= $urandom_range(20, 80);
    end else begin
      ready_left <= ready_left - 1;
    end
    out_tready <= ($urandom_range(0, 99) < ready_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) conv_model.note_pixel(in_tdata);
    if (rst_n && out_tvalid && out_tready) conv_model.check_pixel(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [31:0] data);
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_format(input logic [1:0] idx, input fmt_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    conv_model.set_format(idx, val);
  endtask

  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    // let the monitor record a request accepted at the edge just passed
    @(posedge clk);
    while (conv_model.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic set_formats(input fmt_t src, input fmt_t dst);
    drain_pipe();
    if ($urandom_range(0, 1)) begin
      write_format(CFG_SRC_FMT, src);
      write_format(CFG_DST_FMT, dst);
    end else begin
      write_format(CFG_DST_FMT, dst);
      write_format(CFG_SRC_FMT, src);
    end
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_burst(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) send_pixel({pick_byte(), pick_byte(), pick_byte(), pick_byte()});
      left -= burst;
      if (left > 0 && $urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    int pairs[64];
    int j;
    int tmp;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // gray to gray after reset, unused bytes ignored
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hA5A5_A500);
    send_pixel(32'h5A5A_5AFF);
    // luma extremes
    set_formats(FMT_RGBA, FMT_GRAY);
    send_pixel(32'h00FF_FFFF);
    send_pixel(32'hFF00_00FF);
    send_pixel(32'hFF00_FF00);
    send_pixel(32'hFFFF_0000);
    send_pixel(32'h0000_0000);
    // same layout passes through
    set_formats(FMT_RGBA, FMT_RGBA);
    send_pixel(32'h8040_2010);
    send_pixel(32'hFFFF_FFFF);
    // alpha dropped
    set_formats(FMT_ARGB, FMT_RGB);
    send_pixel(32'h3322_1100);
    send_pixel(32'hFF80_7F01);
    // unused code seven on either side acts as gray
    set_formats(3'd7, FMT_ABGR);
    send_pixel(32'hDEAD_BE7F);
    send_pixel(32'h1234_5600);
    set_formats(FMT_RGB, 3'd7);
    send_pixel(32'h00FF_8040);
    send_pixel(32'hFF00_0000);
    set_formats(FMT_GRAY, FMT_BGRA);
    send_pixel(32'h0102_03C3);

    for (int k = 0; k < 64; k++) pairs[k] = k;
    for (int k = 63; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = pairs[k];
      pairs[k] = pairs[j];
      pairs[j] = tmp;
    end
    foreach (pairs[k]) begin
      set_formats(fmt_t'(pairs[k] / 8), fmt_t'(pairs[k] % 8));
      send_random_burst($urandom_range(8, 18));
    end

    drain_pipe();
    if (conv_model.err_count == 0 && conv_model.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
